// ===== rtl/i2cebm_pkg.sv =====
// Shared types and constants for the two-wire EEPROM byte master.
`default_nettype none

package i2cebm_pkg;

    localparam int unsigned CFG_W = 8;

    typedef enum logic {
        CFG_HALF_PERIOD = 1'b0,
        CFG_ACK_LIMIT   = 1'b1
    } t_cfg_index;

    localparam logic [CFG_W-1:0] HALF_PERIOD_RESET = 8'd5;
    localparam logic [CFG_W-1:0] ACK_LIMIT_RESET   = 8'd250;

    typedef struct packed {
        logic       go;
        logic       kind;
        logic [6:0] device_address;
        logic [7:0] memory_address;
        logic [7:0] write_data;
        logic       sda_in;
    } t_cmd;

    typedef struct packed {
        logic       scl_out;
        logic       sda_release;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_result;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/i2cebm_seq.sv =====
// Bus sequencer: phase state, bit and byte counters, one tick per step.
`default_nettype none

module i2cebm_seq
    import i2cebm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_step,
    input  wire t_cmd             i_cmd,
    output t_result               o_result
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH,
        PH_ACK_LOW, PH_ACK_HIGH, PH_RS_LOW, PH_READ_LOW, PH_READ_HIGH,
        PH_STOP_LOW, PH_STOP_HIGH, PH_STOP_END
    } t_phase;

    logic [7:0] r_half, r_ack_limit;
    t_phase     r_phase, n_phase;
    logic [3:0] r_bit_count, n_bit_count;
    logic [1:0] r_byte_step, n_byte_step;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_tick, n_tick;
    logic [7:0] r_ack_count, n_ack_count;
    logic [6:0] r_device, n_device;
    logic [7:0] r_location, n_location;
    logic [7:0] r_data, n_data;
    logic       r_kind, n_kind;
    logic [7:0] r_received, n_received;

    logic [7:0] half_eff;
    logic [7:0] tick_inc;
    logic       elapsed;
    logic [3:0] bit_inc;
    logic       n_done;
    logic [1:0] levels; // bit 1 SCL, bit 0 SDA

    assign half_eff = (r_half == 8'd0) ? 8'd1 : r_half;
    assign tick_inc = r_tick + 8'd1;
    assign elapsed  = (tick_inc >= half_eff);
    assign bit_inc  = r_bit_count + 4'd1;

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_byte_step = r_byte_step;
        n_shift     = r_shift;
        n_tick      = r_tick;
        n_ack_count = r_ack_count;
        n_device    = r_device;
        n_location  = r_location;
        n_data      = r_data;
        n_kind      = r_kind;
        n_received  = r_received;
        n_done      = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd.go) begin
                    n_kind      = i_cmd.kind;
                    n_device    = i_cmd.device_address;
                    n_location  = i_cmd.memory_address;
                    n_data      = i_cmd.write_data;
                    n_byte_step = 2'd0;
                    n_bit_count = 4'd0;
                    n_ack_count = 8'd0;
                    n_shift     = 8'd0;
                    n_phase     = PH_START_A;
                    n_tick      = 8'd0;
                end
            end
            PH_ACK_HIGH: begin
                if (!i_cmd.sda_in || (r_ack_count >= r_ack_limit)) begin
                    n_bit_count = 4'd0;
                    n_tick      = 8'd0;
                    unique case (r_byte_step)
                        2'd0: begin
                            n_byte_step = 2'd1;
                            n_shift     = r_location;
                            n_phase     = PH_BIT_LOW;
                        end
                        2'd1: begin
                            if (r_kind) begin
                                n_phase = PH_RS_LOW;
                            end else begin
                                n_byte_step = 2'd2;
                                n_shift     = r_data;
                                n_phase     = PH_BIT_LOW;
                            end
                        end
                        default: begin
                            if (r_kind) begin
                                n_byte_step = 2'd3;
                                n_shift     = 8'd0;
                                n_phase     = PH_READ_LOW;
                            end else begin
                                n_phase = PH_STOP_LOW;
                            end
                        end
                    endcase
                end else begin
                    n_ack_count = r_ack_count + 8'd1;
                end
            end
            PH_START_A, PH_START_B, PH_BIT_LOW, PH_BIT_HIGH, PH_ACK_LOW,
            PH_RS_LOW, PH_READ_LOW, PH_READ_HIGH, PH_STOP_LOW, PH_STOP_HIGH,
            PH_STOP_END: begin
                n_tick = tick_inc;
                if (elapsed) begin
                    n_tick = 8'd0;
                    unique case (r_phase)
                        PH_START_A: n_phase = PH_START_B;
                        PH_START_B: begin
                            // second pass through start is the repeated start
                            if (r_byte_step == 2'd1) begin
                                n_byte_step = 2'd2;
                                n_shift     = {r_device, 1'b1};
                            end else begin
                                n_shift     = {r_device, 1'b0};
                            end
                            n_bit_count = 4'd0;
                            n_phase     = PH_BIT_LOW;
                        end
                        PH_BIT_LOW: n_phase = PH_BIT_HIGH;
                        PH_BIT_HIGH: begin
                            n_shift = {r_shift[6:0], 1'b0};
                            if (bit_inc >= 4'd8) begin
                                n_bit_count = 4'd0;
                                n_phase     = PH_ACK_LOW;
                            end else begin
                                n_bit_count = bit_inc;
                                n_phase     = PH_BIT_LOW;
                            end
                        end
                        PH_ACK_LOW: begin
                            n_ack_count = 8'd0;
                            n_phase     = PH_ACK_HIGH;
                        end
                        PH_RS_LOW:   n_phase = PH_START_A;
                        PH_READ_LOW: n_phase = PH_READ_HIGH;
                        PH_READ_HIGH: begin
                            n_shift = {r_shift[6:0], i_cmd.sda_in};
                            if (bit_inc >= 4'd8) begin
                                n_received  = {r_shift[6:0], i_cmd.sda_in};
                                n_bit_count = 4'd0;
                                n_phase     = PH_STOP_LOW;
                            end else begin
                                n_bit_count = bit_inc;
                                n_phase     = PH_READ_LOW;
                            end
                        end
                        PH_STOP_LOW:  n_phase = PH_STOP_HIGH;
                        PH_STOP_HIGH: n_phase = PH_STOP_END;
                        default: begin
                            n_phase = PH_IDLE;
                            n_done  = 1'b1;
                        end
                    endcase
                end
            end
            default: begin
                n_phase = PH_IDLE;
                n_tick  = 8'd0;
            end
        endcase
    end

    always_comb begin
        unique case (n_phase)
            PH_START_B:   levels = 2'b10;
            PH_BIT_LOW:   levels = {1'b0, n_shift[7]};
            PH_BIT_HIGH:  levels = {1'b1, n_shift[7]};
            PH_ACK_LOW,
            PH_RS_LOW,
            PH_READ_LOW:  levels = 2'b01;
            PH_STOP_LOW:  levels = 2'b00;
            PH_STOP_HIGH: levels = 2'b10;
            default:      levels = 2'b11;
        endcase
    end

    assign o_result.scl_out     = levels[1];
    assign o_result.sda_release = levels[0];
    assign o_result.busy_res    = (n_phase != PH_IDLE);
    assign o_result.done_res    = n_done;
    assign o_result.read_result = n_received;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half      <= HALF_PERIOD_RESET;
            r_ack_limit <= ACK_LIMIT_RESET;
            r_phase     <= PH_IDLE;
            r_bit_count <= 4'd0;
            r_byte_step <= 2'd0;
            r_shift     <= 8'd0;
            r_tick      <= 8'd0;
            r_ack_count <= 8'd0;
            r_device    <= 7'd0;
            r_location  <= 8'd0;
            r_data      <= 8'd0;
            r_kind      <= 1'b0;
            r_received  <= 8'd0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_HALF_PERIOD: r_half      <= i_cfg_data;
                    CFG_ACK_LIMIT:   r_ack_limit <= i_cfg_data;
                    default:         r_half      <= r_half;
                endcase
            end
            if (i_step) begin
                r_phase     <= n_phase;
                r_bit_count <= n_bit_count;
                r_byte_step <= n_byte_step;
                r_shift     <= n_shift;
                r_tick      <= n_tick;
                r_ack_count <= n_ack_count;
                r_device    <= n_device;
                r_location  <= n_location;
                r_data      <= n_data;
                r_kind      <= n_kind;
                r_received  <= n_received;
            end
        end
    end

`ifndef SYNTHESIS
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.done_res |=> r_phase == PH_IDLE)
        else $error("done without return to idle");
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit_count < 4'd8)
        else $error("bit counter past byte");
    a_ack_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ACK_HIGH |-> r_bit_count == 4'd0)
        else $error("ack wait with bits pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_step |=> $stable(r_phase) && $stable(r_tick))
        else $error("state moved without a step");
`endif

endmodule

`default_nettype wire

// ===== rtl/i2cebm_out_reg.sv =====
// Result register between the sequencer and the output channel.
`default_nettype none

module i2cebm_out_reg
    import i2cebm_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_load,
    input  wire t_result i_result,
    input  wire logic    i_out_stall,
    output logic         o_free,
    output logic         o_out_valid,
    output t_result      o_result
);

    logic    r_valid;
    t_result r_result;

    // free when empty or its item leaves at this edge
    assign o_free      = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_load) begin
                r_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
        if (i_load) begin
            r_result <= i_result;
        end
    end

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_out_stall |-> !i_load)
        else $error("stalled result overwritten");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && i_out_stall |=> r_valid && $stable(r_result))
        else $error("stalled result changed");
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded item not shown");
`endif

endmodule

`default_nettype wire

// ===== rtl/i2c_eeprom_byte_master_core.sv =====
// Top level: input register, bus sequencer and result register.
// Flow: an accepted item waits in the input register until the result register
// is free; the step that takes it also loads its result into that register.
// Throughput: one item per cycle unless the output stalls; one step per item.
// Reset: synchronous, active low; sequencer idle with both lines released,
// half period 5, ack limit 250, both channels empty.
`default_nettype none

module i2c_eeprom_byte_master_core
    import i2cebm_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic             i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire logic             i_go,
    input  wire logic             i_kind,
    input  wire logic [6:0]       i_device_address,
    input  wire logic [7:0]       i_memory_address,
    input  wire logic [7:0]       i_write_data,
    input  wire logic             i_sda_in,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output logic                  o_scl_out,
    output logic                  o_sda_release,
    output logic                  o_busy_res,
    output logic                  o_done_res,
    output logic [7:0]            o_read_result
);

    logic    r_in_valid;
    t_cmd    r_cmd;
    logic    out_free;
    logic    step;
    logic    in_take;
    t_result seq_result;
    t_result out_result;

    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_cmd.go             <= i_go;
            r_cmd.kind           <= i_kind;
            r_cmd.device_address <= i_device_address;
            r_cmd.memory_address <= i_memory_address;
            r_cmd.write_data     <= i_write_data;
            r_cmd.sda_in         <= i_sda_in;
        end
    end

    i2cebm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (step),
        .i_cmd       (r_cmd),
        .o_result    (seq_result)
    );

    i2cebm_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (step),
        .i_result    (seq_result),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_scl_out     = out_result.scl_out;
    assign o_sda_release = out_result.sda_release;
    assign o_busy_res    = out_result.busy_res;
    assign o_done_res    = out_result.done_res;
    assign o_read_result = out_result.read_result;

`ifndef SYNTHESIS
    a_step_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> r_in_valid)
        else $error("step without a held item");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |=> r_in_valid)
        else $error("held item dropped while stalled");
    a_step_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> o_out_valid)
        else $error("stepped item produced no result");
`endif

endmodule

`default_nettype wire
